// ----- rtl/ip6tp_pkg.sv -----
// shared constants, types and helpers for the ipv6 text address parser
package ip6tp_pkg;

  localparam int NumGroups = 8;
  localparam int GroupW = 16;
  localparam int CountW = 5;
  localparam int GapW = 5;
  localparam int CharW = 8;
  localparam int HalfW = 64;
  localparam int HexAlphaBase = 10;
  localparam int QueueDepthDefault = 2;

  localparam logic [CharW-1:0] ColonChar = 8'h3A;
  localparam logic [CountW-1:0] CountMax = 5'd31;

  typedef logic [NumGroups-1:0][GroupW-1:0] groups_t;

  // one parsed address, as the front closes it on the final character
  typedef struct packed {
    groups_t groups;
    logic [CountW-1:0] count;
    logic gap_seen;
    logic [GapW-1:0] gap_pos;
  } rec_t;

  function automatic logic [3:0] nibble_of(input logic [CharW-1:0] ch);
    logic [CharW-1:0] diff;
    diff = ch - 8'h30;
    if (ch >= 8'h41 && ch <= 8'h46) begin
      diff = ch - 8'h41 + 8'(HexAlphaBase);
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      diff = ch - 8'h61 + 8'(HexAlphaBase);
    end
    return diff[3:0];
  endfunction

endpackage

// ----- rtl/ip6tp_char_if.sv -----
// character channel: one text character per transfer
interface ip6tp_char_if;
  logic valid;
  logic ready;
  logic [ip6tp_pkg::CharW-1:0] char_in;
  logic last_char;

  modport source(output valid, char_in, last_char, input ready);
  modport sink(input valid, char_in, last_char, output ready);
  modport monitor(input valid, ready, char_in, last_char);
endinterface

// ----- rtl/ip6tp_addr_if.sv -----
// address channel: one 128-bit address per transfer, in two halves
interface ip6tp_addr_if;
  logic valid;
  logic ready;
  logic [ip6tp_pkg::HalfW-1:0] addr_high;
  logic [ip6tp_pkg::HalfW-1:0] addr_low;

  modport source(output valid, addr_high, addr_low, input ready);
  modport sink(input valid, addr_high, addr_low, output ready);
  modport monitor(input valid, ready, addr_high, addr_low);
endinterface

// ----- rtl/ip6tp_front.sv -----
// front: takes characters, builds groups, closes an address record on the last one
module ip6tp_front (
  input  logic               clk,
  input  logic               rst,
  ip6tp_char_if.sink         text,
  output logic               push_valid,
  input  logic               push_ready,
  output ip6tp_pkg::rec_t    push_rec
);

  ip6tp_pkg::groups_t groups, groups_next;
  logic [ip6tp_pkg::CountW-1:0] count, count_next;
  logic gap_seen, gap_seen_next;
  logic [ip6tp_pkg::GapW-1:0] gap_pos, gap_pos_next;
  logic prev_colon;

  logic is_colon;
  logic take;
  logic [2:0] idx;

  assign text.ready = push_ready;
  assign take = text.valid && text.ready;
  assign is_colon = (text.char_in == ip6tp_pkg::ColonChar);
  assign idx = count[2:0];

  always_comb begin
    groups_next = groups;
    count_next = count;
    gap_seen_next = gap_seen;
    gap_pos_next = gap_pos;
    if (is_colon) begin
      if (prev_colon) begin
        gap_seen_next = 1'b1;
        gap_pos_next = count;
      end
    end else if (count < ip6tp_pkg::CountW'(ip6tp_pkg::NumGroups)) begin
      groups_next[idx] = {groups[idx][ip6tp_pkg::GroupW-5:0],
                          ip6tp_pkg::nibble_of(text.char_in)};
    end
    if ((is_colon || text.last_char) && count != ip6tp_pkg::CountMax) begin
      count_next = count + 1'b1;
    end
  end

  assign push_valid = take && text.last_char;
  assign push_rec = '{groups: groups_next, count: count_next,
                      gap_seen: gap_seen_next, gap_pos: gap_pos_next};

  always_ff @(posedge clk) begin
    if (rst || (take && text.last_char)) begin
      groups <= '0;
      count <= '0;
      gap_seen <= 1'b0;
      gap_pos <= '0;
      prev_colon <= 1'b0;
    end else if (take) begin
      groups <= groups_next;
      count <= count_next;
      gap_seen <= gap_seen_next;
      gap_pos <= gap_pos_next;
      prev_colon <= is_colon;
    end
  end

endmodule

// ----- rtl/ip6tp_queue.sv -----
// short register queue of closed address records between front and back
module ip6tp_queue #(
  parameter int Depth = ip6tp_pkg::QueueDepthDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  ip6tp_pkg::rec_t push_rec,
  output logic            pop_valid,
  input  logic            pop_ready,
  output ip6tp_pkg::rec_t pop_rec
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  ip6tp_pkg::rec_t entries [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] fill;
  logic do_push, do_pop;

  assign push_ready = (fill != FullCnt);
  assign pop_valid = (fill != '0);
  assign pop_rec = entries[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/ip6tp_back.sv -----
// back: expands the zero run and holds the address in the output register
module ip6tp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  ip6tp_pkg::rec_t pop_rec,
  ip6tp_addr_if.source    addr
);

  function automatic ip6tp_pkg::groups_t expand(input ip6tp_pkg::rec_t r);
    ip6tp_pkg::groups_t g;
    logic apply;
    logic [3:0] z;
    logic [4:0] pz;
    logic [3:0] src;
    apply = r.gap_seen && (r.count <= ip6tp_pkg::CountW'(ip6tp_pkg::NumGroups));
    z = 4'(ip6tp_pkg::NumGroups) - r.count[3:0];
    pz = r.gap_pos + 5'(z);
    for (int i = 0; i < ip6tp_pkg::NumGroups; i++) begin
      src = 4'(i) - z;
      if (apply && 5'(i) > pz) begin
        // later groups slide down to the bottom of the address
        g[i] = r.groups[src[2:0]];
      end else if (apply && 5'(i) > r.gap_pos) begin
        g[i] = '0;
      end else begin
        g[i] = r.groups[i];
      end
    end
    return g;
  endfunction

  ip6tp_pkg::groups_t g_full;
  logic out_valid;

  assign g_full = expand(pop_rec);
  assign pop_ready = !out_valid || addr.ready;
  assign addr.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop_ready) begin
      out_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      addr.addr_high <= {g_full[0], g_full[1], g_full[2], g_full[3]};
      addr.addr_low <= {g_full[4], g_full[5], g_full[6], g_full[7]};
    end
  end

endmodule

// ----- rtl/ipv6_text_address_parser.sv -----
// top level of the ipv6 text address parser
// Takes the text of an IPv6 address one character per cycle, with no gaps
// needed between characters or between addresses. The front updates its
// group registers in the cycle a character is taken; on the final character
// it closes the address into a small queue (QueueDepth records). The back
// expands the zero run with an eight-way group multiplexer and registers the
// two 64-bit halves, so an address passes through a queue entry and then the
// output register. Input ready drops only when the queue is full, that is
// when the output has been stalled for several addresses. Malformed text
// gives an unspecified address, never an error.
module ipv6_text_address_parser #(
  parameter int QueueDepth = ip6tp_pkg::QueueDepthDefault
) (
  input logic          clk,
  input logic          rst,
  ip6tp_char_if.sink   text,
  ip6tp_addr_if.source addr
);

  logic push_valid, push_ready;
  logic pop_valid, pop_ready;
  ip6tp_pkg::rec_t push_rec, pop_rec;

  ip6tp_front u_front (
    .clk(clk),
    .rst(rst),
    .text(text),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_rec(push_rec)
  );

  ip6tp_queue #(.Depth(QueueDepth)) u_queue (
    .clk(clk),
    .rst(rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_rec(push_rec),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_rec(pop_rec)
  );

  ip6tp_back u_back (
    .clk(clk),
    .rst(rst),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_rec(pop_rec),
    .addr(addr)
  );

endmodule

// ----- rtl/ip6tp_checker.sv -----
// port-level checks for the ipv6 text address parser, bound to the top level
module ip6tp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        text_valid,
  input logic                        text_ready,
  input logic                        text_last,
  input logic                        addr_valid,
  input logic                        addr_ready,
  input logic [ip6tp_pkg::HalfW-1:0] addr_high,
  input logic [ip6tp_pkg::HalfW-1:0] addr_low
);

  // no address is shown right after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !addr_valid)
    else $error("address valid right after reset");

  // an idle output only wakes up after a final character transfer has passed the queue and the output register
  a_rise_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(addr_valid) |-> $past(text_valid && text_ready && text_last, 2))
    else $error("address appeared without a final character");

  // a stalled address holds its value
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    addr_valid && !addr_ready |=>
      addr_valid && $stable(addr_high) && $stable(addr_low))
    else $error("stalled address changed");

  // with the output idle, a final character shows an address once it has passed the queue and the output register
  a_idle_latency: assert property (@(posedge clk) disable iff (rst)
    text_valid && text_ready && text_last && !addr_valid |=> ##1 addr_valid)
    else $error("address missing after a final character");

endmodule

bind ipv6_text_address_parser ip6tp_checker u_checker (
  .clk(clk),
  .rst(rst),
  .text_valid(text.valid),
  .text_ready(text.ready),
  .text_last(text.last_char),
  .addr_valid(addr.valid),
  .addr_ready(addr.ready),
  .addr_high(addr.addr_high),
  .addr_low(addr.addr_low)
);
